/* hdl/assert_macros.svh */
// Assertion macros for the battery monitor RTL.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BMAM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define BMAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bmam_pkg.sv */
// Shared types and constants for the battery moving-average monitor.
// No dependencies.
package bmam_pkg;

	localparam int WINDOW = 50;
	localparam int CODE_W = 12;
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = CODE_W + $clog2(WINDOW);
	localparam int STEP_W = $clog2(SUM_W + 1);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [1:0]        level_t;
	typedef logic [1:0]        cfg_idx_t;

	localparam level_t LVL_OK   = 2'd0;
	localparam level_t LVL_LOW  = 2'd1;
	localparam level_t LVL_CRIT = 2'd2;

	localparam cfg_idx_t REG_LOW_THR  = 2'd0;
	localparam cfg_idx_t REG_CRIT_THR = 2'd1;

	localparam code_t LOW_THR_RST  = 12'd2296;
	localparam code_t CRIT_THR_RST = 12'd2172;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/bmam_div.sv */
// Restoring serial divider: running sum by sample count, one quotient bit per cycle.
// Depends on bmam_pkg.
module bmam_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bmam_pkg::sum_t     dividend,
	input  bmam_pkg::cnt_t     divisor,
	output bmam_pkg::code_t    quotient,
	output bmam_pkg::div_stat_t stat
);
	import bmam_pkg::*;

	sum_t              dvd_q;
	logic [CNT_W:0]    rem_q;
	cnt_t              dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0] shifted;
	logic [CNT_W:0] diff;
	logic           ge;

	// remainder stays below the divisor, so its low CNT_W bits carry it all
	assign shifted = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff : shifted;
		end
	end

	// mean never exceeds a code, so the upper quotient bits are zero
	assign quotient  = dvd_q[CODE_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hdl/battery_moving_average_monitor_core.sv */
// Top level of the battery moving-average monitor: sample ring, running sum,
// sequencer and threshold grading. Depends on bmam_pkg, bmam_div, assert_macros.svh.
//
// Usage:
//   Input channel: in_valid / in_stall with one 12-bit ADC code on sample.
//   Output channel: out_valid / out_stall with average, level, shutdown.
//   Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   0 = low threshold, 1 = critical threshold; other indexes are dropped.
//   Write thresholds only while no request is in flight.
// Timing:
//   A request accepted while idle steps in order through the ring read at the
//   accept edge, the sum update and ring write, loading the divider, the
//   bit-serial divide, handing the quotient over, and grading into the output
//   register. in_stall is high during that whole span and drops once the
//   block is idle again, so a new sample is taken only after the last is done.
// Reset: ring pointer, fill flag and sum clear, thresholds return to
//   2296 and 2172; ring contents stay undefined until written.
// Stall: a result waits in the output register; the next request is still
//   taken and runs up to grading, where it holds until the register frees.
`include "assert_macros.svh"
module battery_moving_average_monitor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bmam_pkg::code_t    sample,
	output logic               out_valid,
	input  logic               out_stall,
	output bmam_pkg::code_t    average,
	output bmam_pkg::level_t   level,
	output logic               shutdown,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  bmam_pkg::cfg_idx_t cfg_index,
	input  bmam_pkg::code_t    cfg_data
);
	import bmam_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UPD  = 5'b00010,
		S_LOAD = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t    state_q;
	code_t     ring [WINDOW];
	code_t     rd_q;
	code_t     sample_q;
	ptr_t      ptr_q;
	logic      filled_q;
	sum_t      sum_q;
	cnt_t      cnt_q;
	code_t     low_thr_q;
	code_t     crit_thr_q;
	logic      out_valid_q;
	code_t     average_q;
	level_t    level_q;
	logic      shutdown_q;

	logic      accept;
	logic      last_slot;
	ptr_t      ptr_nx;
	logic      filled_nx;
	logic      load_out;
	code_t     quot;
	div_stat_t div_stat;
	level_t    level_nx;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign last_slot = (ptr_q == PTR_W'(WINDOW - 1));
	assign ptr_nx    = last_slot ? '0 : ptr_q + 1'b1;
	assign filled_nx = filled_q || last_slot;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		if (quot < crit_thr_q) begin
			level_nx = LVL_CRIT;
		end else if (quot < low_thr_q) begin
			level_nx = LVL_LOW;
		end else begin
			level_nx = LVL_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_UPD;
				end
				S_UPD:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ring pointer, fill flag and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
		end else if (state_q == S_UPD) begin
			ptr_q    <= ptr_nx;
			filled_q <= filled_nx;
			sum_q    <= sum_q - (filled_q ? SUM_W'(rd_q) : '0) + SUM_W'(sample_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			cnt_q <= filled_nx ? CNT_W'(WINDOW) : CNT_W'(ptr_nx);
		end
		if (accept) begin
			sample_q <= sample;
		end
	end

	// sample ring: read the outgoing entry on accept, overwrite it in the next cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= ring[ptr_q];
		end
		if (state_q == S_UPD) begin
			ring[ptr_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_THR_RST;
			crit_thr_q <= CRIT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_THR:  low_thr_q  <= cfg_data;
				REG_CRIT_THR: crit_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_LOAD),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.quotient (quot),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q  <= quot;
			level_q    <= level_nx;
			shutdown_q <= (quot != '0) && (quot < crit_thr_q);
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign level     = level_q;
	assign shutdown  = shutdown_q;

	`BMAM_ASSERT_NEXT(a_accept_upd, accept, state_q == S_UPD, "accepted request did not start update")
	`BMAM_ASSERT(a_out_from_grade, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result appeared outside grading")
	`BMAM_ASSERT(a_div_count, (state_q == S_DIV) |-> (cnt_q != '0 && cnt_q <= CNT_W'(WINDOW)), "divisor out of range")
	`BMAM_ASSERT(a_shut_crit, out_valid_q |-> (!shutdown_q || level_q == LVL_CRIT), "shutdown without critical level")

endmodule
